// ===== rtl/core/ibt_pkg.sv =====
// Shared types and default constants for the interval booking table.
package ibt_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int REQ_W         = 32;
  localparam int HELD_W        = 7;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

endpackage

// ===== rtl/core/ibt_slot_table.sv =====
// Booking slot registers with the parallel overlap compare against a request.
module ibt_slot_table
  import ibt_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TIME_BITS-1:0] q_start,
  input  logic [TIME_BITS-1:0] q_end,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  output logic                 hit
);

  logic [TIME_BITS-1:0] slot_start_r [ENTRIES];
  logic [TIME_BITS-1:0] slot_end_r   [ENTRIES];
  logic [ENTRIES-1:0]   slot_valid_r;
  logic [ENTRIES-1:0]   conflict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (wr_en) begin
      slot_valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_start_r[wr_idx] <= q_start;
      slot_end_r[wr_idx]   <= q_end;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      conflict[i] = slot_valid_r[i] && (slot_start_r[i] < q_end) && (slot_end_r[i] > q_start);
    end
  end

  assign hit = |conflict;

endmodule

// ===== rtl/core/interval_booking_table.sv =====
// Top level of the interval booking table: request register, decision, result register.
// Each request [in_req_start, in_req_end) is registered, compared in parallel against
// every held booking, and answered by a one-cycle out_valid strobe (in_vld_r, then
// out_valid_r); busy stays low, so a request may be issued every cycle and each one sees
// the bookings made by all earlier requests. Requests with end <= start report invalid,
// a conflict with any held booking reports overlap, otherwise the booking goes to the
// next free slot or, with all slots used, reports table full. out_held_count is the
// number of bookings held after the request. Results cannot be stalled; the table is
// empty after reset.
module interval_booking_table
  import ibt_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  in_req_start,
  input  logic [REQ_W-1:0]  in_req_end,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [HELD_W-1:0] out_held_count
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [TIME_BITS-1:0] req_s;
  logic [TIME_BITS-1:0] req_e;
  logic                 in_vld_r;
  logic [TIME_BITS-1:0] in_start_r;
  logic [TIME_BITS-1:0] in_end_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 hit;
  logic                 invalid;
  logic                 full;
  logic                 book;
  status_t              status_nxt;
  logic                 out_valid_r;
  status_t              status_r;
  logic [HELD_W-1:0]    held_r;

  generate
    if (TIME_BITS >= REQ_W) begin : g_wide
      assign req_s = TIME_BITS'(in_req_start);
      assign req_e = TIME_BITS'(in_req_end);
    end else begin : g_narrow
      assign req_s = in_req_start[TIME_BITS-1:0];
      assign req_e = in_req_end[TIME_BITS-1:0];
    end
  endgenerate

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_start_r <= req_s;
      in_end_r   <= req_e;
    end
  end

  ibt_slot_table #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_start (in_start_r),
    .q_end   (in_end_r),
    .wr_en   (book),
    .wr_idx  (IDX_W'(count_r)),
    .hit     (hit)
  );

  assign invalid = (in_end_r <= in_start_r);
  assign full    = (count_r == CNT_W'(ENTRIES));
  assign book    = in_vld_r && !invalid && !hit && !full;

  always_comb begin
    if (invalid) begin
      status_nxt = ST_INVALID;
    end else if (hit) begin
      status_nxt = ST_OVERLAP;
    end else if (full) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_BOOKED;
    end
  end

  assign count_nxt = book ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      status_r <= status_nxt;
      held_r   <= HELD_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_held_count = held_r;

endmodule
